/* rtl/lrupr_pkg.sv */
// Shared constants and types for the LRU page replacement unit.
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int PAGE_W  = 16;  // page number port width
    localparam int CFG_W   = 4;   // frames_in_use register width
    localparam int COUNT_W = 32;  // fault counter width

    localparam logic [CFG_W-1:0] FIU_RESET = 4'd8;

    // outcome of one lookup
    typedef struct packed {
        logic fault;   // page was not resident
        logic evict;   // a resident page was replaced
    } t_lookup;

endpackage

/* rtl/lrupr_frame_table.sv */
// Frame table: page tags, valid marks, recency ranks, lookup and update.
module lrupr_frame_table
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int AW        = $clog2(FRAMES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_flush,
    input  logic [AW-1:0]        i_active,
    input  logic                 i_req,
    input  logic [PAGE_BITS-1:0] i_page,
    output t_lookup              o_lookup,
    output logic [PAGE_BITS-1:0] o_evicted_page
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic [PAGE_BITS-1:0] r_page [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [RW-1:0]        r_rank [FRAMES];

    logic [FRAMES-1:0]    hit_vec, free_vec, vict_vec;
    logic [FRAMES-1:0]    hit_first, free_first, tgt_vec;
    logic                 hit, free_found;
    logic [RW-1:0]        hit_rank;
    logic [AW-1:0]        last_rank;
    logic [PAGE_BITS-1:0] ev_page;
    logic [RW-1:0]        n_rank [FRAMES];

    assign last_rank = i_active - AW'(1);

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            logic act;
            act         = (AW'(i) < i_active);
            hit_vec[i]  = act && r_valid[i] && (r_page[i] == i_page);
            free_vec[i] = act && !r_valid[i];
            // full table: least recent frame holds the highest rank
            vict_vec[i] = act && r_valid[i] && (AW'(r_rank[i]) == last_rank);
        end
    end

    // lowest set bit
    assign hit_first  = hit_vec  & ~(hit_vec  - FRAMES'(1));
    assign free_first = free_vec & ~(free_vec - FRAMES'(1));
    assign hit        = |hit_vec;
    assign free_found = |free_vec;
    assign tgt_vec    = hit ? hit_first : (free_found ? free_first : vict_vec);

    always_comb begin
        hit_rank = '0;
        ev_page  = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (hit_first[i]) begin
                hit_rank = hit_rank | r_rank[i];
            end
            if (vict_vec[i]) begin
                ev_page = ev_page | r_page[i];
            end
        end
    end

    // target goes to front; frames ahead of it move back one place
    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            if (tgt_vec[i]) begin
                n_rank[i] = '0;
            end else if (r_valid[i] && (!hit || (r_rank[i] < hit_rank))) begin
                n_rank[i] = r_rank[i] + RW'(1);
            end else begin
                n_rank[i] = r_rank[i];
            end
        end
    end

    assign o_lookup.fault = !hit;
    assign o_lookup.evict = !hit && !free_found;
    assign o_evicted_page = (!hit && !free_found) ? ev_page : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_valid <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_req) begin
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= n_rank[i];
                if (tgt_vec[i]) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    // tags carry no reset; only read where valid
    always_ff @(posedge i_clk) begin
        if (i_req && !i_flush && !hit) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (tgt_vec[i]) begin
                    r_page[i] <= i_page;
                end
            end
        end
    end

endmodule

/* rtl/lru_page_replacement_unit.sv */
// LRU page replacement unit: one page reference a cycle, fault and victim report.
// The result of a taken word is held in the result register and strobed by o_valid
// for one cycle. Throughput: one word per cycle, o_busy stays low.
// The lookup and the recency update sit between the input register and the result register.
// Reset (synchronous, active low) empties every frame, zeroes the fault count and sets
// frames_in_use to 8. The receiver cannot stall; each result shows for one cycle only.
module lru_page_replacement_unit
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // reference channel
    input  logic               i_start,
    output logic               o_busy,
    input  logic [PAGE_W-1:0]  i_page_number,
    // result channel
    output logic               o_valid,
    output logic               o_page_fault,
    output logic               o_evicted_valid,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic [COUNT_W-1:0] o_fault_count,
    // frames_in_use write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int AW = $clog2(FRAMES + 1);

    // input register
    logic                 r_in_valid;
    logic [PAGE_BITS-1:0] r_in_page;
    logic [PAGE_BITS-1:0] n_in_page;

    // configuration
    logic [CFG_W-1:0]     r_fiu;
    logic [AW-1:0]        active;
    logic                 cfg_wr;

    // result register
    logic                 r_out_valid;
    logic                 r_fault;
    logic                 r_evict;
    logic [PAGE_W-1:0]    r_ev_page;
    logic [PAGE_W-1:0]    n_ev_page;
    logic [COUNT_W-1:0]   r_count;

    t_lookup              lookup;
    logic [PAGE_BITS-1:0] ev_page;

    // every word is taken; the table lookup is combinational
    assign o_busy      = 1'b0;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // only the low PAGE_BITS of the page take part
    always_comb begin
        for (int b = 0; b < PAGE_BITS; b++) begin
            n_in_page[b] = (b < PAGE_W) ? i_page_number[b % PAGE_W] : 1'b0;
        end
        for (int b = 0; b < PAGE_W; b++) begin
            n_ev_page[b] = (b < PAGE_BITS) ? ev_page[b % PAGE_BITS] : 1'b0;
        end
    end

    // zero means one frame, anything above the table size means all of it
    always_comb begin
        if (r_fiu == '0) begin
            active = AW'(1);
        end else if (int'(r_fiu) > FRAMES) begin
            active = AW'(FRAMES);
        end else begin
            active = AW'(r_fiu);
        end
    end

    lrupr_frame_table #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .AW        (AW)
    ) u_table (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flush        (cfg_wr),
        .i_active       (active),
        .i_req          (r_in_valid),
        .i_page         (r_in_page),
        .o_lookup       (lookup),
        .o_evicted_page (ev_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fiu       <= FIU_RESET;
            r_count     <= '0;
        end else begin
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
            if (cfg_wr) begin
                r_fiu <= i_cfg_data;
            end
            // saturating fault count
            if (r_in_valid && lookup.fault && (r_count != '1)) begin
                r_count <= r_count + COUNT_W'(1);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in_page <= n_in_page;
        end
        if (r_in_valid) begin
            r_fault   <= lookup.fault;
            r_evict   <= lookup.evict;
            r_ev_page <= n_ev_page;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_page_fault    = r_fault;
    assign o_evicted_valid = r_evict;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_count;

endmodule

/* sim/lrupr_checker.sv */
// Reference-predicting checker for the LRU page replacement unit.
module lrupr_checker
    import lrupr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [PAGE_W-1:0]  i_page_number,
    input  logic               i_valid,
    input  logic               i_page_fault,
    input  logic               i_evicted_valid,
    input  logic [PAGE_W-1:0]  i_evicted_page,
    input  logic [COUNT_W-1:0] i_fault_count,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int NFRAMES = FRAMES_DEF;

    typedef struct packed {
        logic               fault;
        logic               evicted;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_count;
    } t_outcome;

    logic [PAGE_W-1:0]  frame_page  [NFRAMES];
    logic               frame_valid [NFRAMES];
    int unsigned        frame_rank  [NFRAMES];
    logic [COUNT_W-1:0] fault_total;
    logic [CFG_W-1:0]   frames_reg;

    t_outcome outcome_q [$];
    int       fails   = 0;
    int       pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic void empty_frames();
        for (int i = 0; i < NFRAMES; i++) begin
            frame_page[i]  = '0;
            frame_valid[i] = 1'b0;
            frame_rank[i]  = 0;
        end
    endfunction

    // zero means one frame, anything above the table size means all of it
    function automatic int active_frames();
        if (frames_reg == '0)
            return 1;
        if (int'(frames_reg) > NFRAMES)
            return NFRAMES;
        return int'(frames_reg);
    endfunction

    // frame f becomes most recent; valid frames ranked below limit age by one
    function automatic void promote(int n, int f, int unsigned limit);
        for (int i = 0; i < n; i++) begin
            if (i != f && frame_valid[i] && frame_rank[i] < limit)
                frame_rank[i]++;
        end
        frame_rank[f] = 0;
    endfunction

    function automatic t_outcome reference_page(logic [PAGE_W-1:0] page);
        t_outcome    res;
        int          n;
        bit          hit, free_found;
        int          hit_idx, free_idx, victim;
        int unsigned victim_rank;
        res         = '0;
        n           = active_frames();
        hit         = 1'b0;
        free_found  = 1'b0;
        hit_idx     = 0;
        free_idx    = 0;
        victim      = 0;
        victim_rank = 0;
        for (int i = 0; i < n; i++) begin
            if (frame_valid[i]) begin
                if (!hit && frame_page[i] == page) begin
                    hit     = 1'b1;
                    hit_idx = i;
                end
                if (frame_rank[i] >= victim_rank) begin
                    victim_rank = frame_rank[i];
                    victim      = i;
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_idx   = i;
            end
        end
        if (hit) begin
            promote(n, hit_idx, frame_rank[hit_idx]);
        end else begin
            res.fault = 1'b1;
            if (fault_total != '1)
                fault_total++;
            if (free_found) begin
                frame_page[free_idx]  = page;
                frame_valid[free_idx] = 1'b1;
                promote(n, free_idx, 32'hFFFF_FFFF);
            end else begin
                res.evicted      = 1'b1;
                res.evicted_page = frame_page[victim];
                frame_page[victim] = page;
                promote(n, victim, 32'hFFFF_FFFF);
            end
        end
        res.fault_count = fault_total;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            empty_frames();
            fault_total = '0;
            frames_reg  = FIU_RESET;
            outcome_q.delete();
        end else begin
            // the word on the outputs now can never be the one taken at this edge
            if (i_valid) begin
                if (outcome_q.size() == 0) begin
                    $error("result word with nothing outstanding");
                    fails++;
                end else begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    if (i_page_fault !== want.fault) begin
                        $error("page_fault: expected %0d, got %0d", want.fault, i_page_fault);
                        fails++;
                    end
                    if (i_evicted_valid !== want.evicted) begin
                        $error("evicted_valid: expected %0d, got %0d",
                               want.evicted, i_evicted_valid);
                        fails++;
                    end
                    if (i_evicted_page !== want.evicted_page) begin
                        $error("evicted_page: expected %h, got %h",
                               want.evicted_page, i_evicted_page);
                        fails++;
                    end
                    if (i_fault_count !== want.fault_count) begin
                        $error("fault_count: expected %0d, got %0d",
                               want.fault_count, i_fault_count);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                frames_reg = i_cfg_data;
                empty_frames();
            end
            if (i_start && !i_busy)
                outcome_q = {outcome_q, reference_page(i_page_number)};
        end
        pending = outcome_q.size();
    end

endmodule

/* sim/testbench.sv */
// Stimulus, clock, reset, watchdog and verdict for the LRU page replacement unit.
module testbench;
    import lrupr_pkg::*;

    // cycles with no word moving on any channel before the run is called dead;
    // the longest legitimate quiet spells come from long sender gaps and drains
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEM_TARGET    = 1100;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [PAGE_W-1:0]  page_number;
    logic               res_valid;
    logic               res_fault;
    logic               res_evicted_valid;
    logic [PAGE_W-1:0]  res_evicted_page;
    logic [COUNT_W-1:0] res_fault_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int pages_sent   = 0;
    bit no_idle      = 1'b0;

    // frame counts for the first random phases: extremes, both out-of-range
    // cases (zero and above the table size) and the values in between
    int frames_plan [12] = '{1, 8, 0, 15, 2, 7, 3, 9, 5, 4, 6, 12};

    lru_page_replacement_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_page_number   (page_number),
        .o_valid         (res_valid),
        .o_page_fault    (res_fault),
        .o_evicted_valid (res_evicted_valid),
        .o_evicted_page  (res_evicted_page),
        .o_fault_count   (res_fault_count),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    lrupr_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_page_number   (page_number),
        .i_valid         (res_valid),
        .i_page_fault    (res_fault),
        .i_evicted_valid (res_evicted_valid),
        .i_evicted_page  (res_evicted_page),
        .i_fault_count   (res_fault_count),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: any word moving on any channel resets the quiet count
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // sender gap after a word: mostly none, some short, a few long;
    // whole phases run flat out when no_idle is set
    task automatic sender_gap();
        int roll;
        int gap;
        if (no_idle)
            return;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // present one page reference and hold it until taken; busy is read at the
    // falling edge to decide whether the next rise takes the word
    task automatic send_page(logic [PAGE_W-1:0] page);
        bit taken;
        start       <= 1'b1;
        page_number <= page;
        do begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
        pages_sent++;
        sender_gap();
    endtask

    // stop sending, let every outstanding result drain, then idle before returning
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // frames_in_use write; only ever issued with the unit drained
    task automatic write_frames(logic [CFG_W-1:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    initial begin
        int                phase;
        int                span;
        int                live_frames;
        logic [CFG_W-1:0]  frames_sel;
        logic [PAGE_W-1:0] base;
        logic [PAGE_W-1:0] page_pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        page_number = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, reset frame count of 8: page field extremes, a hit, filling
        // every frame, then two misses on a full table evicting the oldest page
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        for (int p = 1; p <= 6; p++)
            send_page(PAGE_W'(p));
        send_page(16'hFFFF);
        send_page(16'h1234);
        send_page(16'h0000);
        drain();

        // zero frames behaves as a single frame; every miss after the first evicts
        write_frames(4'd0);
        send_page(16'hAAAA);
        send_page(16'hAAAA);
        send_page(16'h5555);
        send_page(16'hAAAA);
        drain();

        // top of the register range saturates to the table size;
        // the write also empties the frames left over from before
        write_frames(4'd15);
        send_page(16'h8000);
        send_page(16'h7FFF);
        send_page(16'h8000);
        send_page(16'h0001);
        drain();

        write_frames(4'd1);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        drain();

        // random phases: each a fresh frame count and a small working set around a
        // random base, so hits, fills and evictions all stay frequent; a tenth of
        // the references are fully random pages
        phase = 0;
        while (pages_sent < ITEM_TARGET) begin
            frames_sel = (phase < 12) ? CFG_W'(frames_plan[phase])
                                      : CFG_W'($urandom_range(0, 15));
            write_frames(frames_sel);
            if (frames_sel == '0)
                live_frames = 1;
            else if (int'(frames_sel) > FRAMES_DEF)
                live_frames = FRAMES_DEF;
            else
                live_frames = int'(frames_sel);
            no_idle = ($urandom_range(0, 3) == 0);
            base    = PAGE_W'($urandom);
            span    = $urandom_range(40, 120);
            repeat (span) begin
                if ($urandom_range(0, 9) == 0)
                    page_pick = PAGE_W'($urandom);
                else
                    page_pick = base ^ PAGE_W'($urandom_range(0, live_frames + 2));
                send_page(page_pick);
            end
            drain();
            phase++;
        end

        no_idle = 1'b0;
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
